/* rtl/escaped_byte_rx_fifo_unit_defines.svh */
// Assertion macros shared by the checker of the escaped byte receive FIFO.
`ifndef ESCAPED_BYTE_RX_FIFO_UNIT_DEFINES_SVH
`define ESCAPED_BYTE_RX_FIFO_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define EBRF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define EBRF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ebrf_pkg.sv */
// Types and constants of the escaped byte receive FIFO.
package ebrf_pkg;

   localparam int BYTE_W = 8;
   localparam int MARK_W = 9;

   // Link byte codes
   localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h5C;
   localparam logic [BYTE_W-1:0] IDLE_LOW  = 8'h00;
   localparam logic [BYTE_W-1:0] IDLE_HIGH = 8'hFF;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_HIGH_MARK = 1'b0,
      CSR_LOW_MARK  = 1'b1
   } csr_index_type;

   // Unescape decision for one link byte
   typedef struct packed {
      logic keep;
      logic escape_next;
   } unesc_type;

endpackage

/* rtl/escaped_byte_rx_fifo_unit.sv */
// Top level of the escaped byte receive FIFO with high and low watermark events.
//
// The block takes one request per clock cycle: busy stays low, so every cycle
// with start high is an accepted request. Each request gives exactly one result,
// strobed on rsp_strobe in the cycle right after acceptance; the receiver must
// take it then. That rate comes from the byte store,
// a single memory with one write port and one registered read port: a link byte
// is written at the accepting edge, and a pop reads the head entry at the
// accepting edge so the byte is ready with the strobe. Pointer and count
// updates land at the same edge, so a request in the next cycle sees them.
// The store needs no clearing after reset; only written entries are ever popped.
// A full FIFO drops its oldest PURGE_BLOCK bytes before taking a new one.
// Configuration writes take effect at once and belong to idle periods.
module escaped_byte_rx_fifo_unit #(
   parameter int DEPTH       = 256,
   parameter int PURGE_BLOCK = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [ebrf_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                                rsp_strobe,
   output logic                                rsp_stored,
   output logic                                rsp_high_event,
   output logic                                rsp_low_event,
   output logic                                rsp_read_valid,
   output logic [ebrf_pkg::BYTE_W-1:0]         rsp_read_byte,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_fill_level,
   input  logic                                csr_write_en,
   input  ebrf_pkg::csr_index_type             csr_index,
   input  logic [ebrf_pkg::MARK_W-1:0]         csr_wdata
);
   import ebrf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W + 1 > MARK_W + 1) ? CNT_W + 1 : MARK_W + 1;
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
   localparam logic [SUM_W-1:0] PURGE_S = SUM_W'(PURGE_BLOCK);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] PURGE_C = CNT_W'(PURGE_BLOCK);

   // Byte store
   logic [BYTE_W-1:0] fifo_mem [DEPTH];

   // State registers
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              escape_ff, escape_in;
   logic              high_sent_ff, high_sent_in;
   logic [MARK_W-1:0] high_mark_ff, low_mark_ff;

   // Result registers
   logic              strobe_ff;
   logic              stored_ff, stored_in;
   logic              high_ev_ff, high_ev_in;
   logic              low_ev_ff, low_ev_in;
   logic              read_valid_ff, read_valid_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]  fill_ff;

   logic              accept;
   unesc_type         dec;
   logic              wr_en;
   logic              rd_en;
   logic [PTR_W-1:0]  wr_addr;
   logic              full;
   logic [SUM_W-1:0]  purge_sum, head_p_sum, wr_sum, pop_sum;
   logic [PTR_W-1:0]  head_p;
   logic [CNT_W-1:0]  cnt_p;
   logic [CMP_W-1:0]  count_plus, high_cmp, low_cmp;
   logic              high_hit, low_hit, high_mid;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ebrf_unescape u_unescape (
      .rx_byte        (req_rx_byte),
      .escape_pending (escape_ff),
      .dec            (dec)
   );

   // Purge on full, then find the tail slot
   assign full       = (count_ff == DEPTH_C);
   assign purge_sum  = SUM_W'(head_ff) + PURGE_S;
   assign head_p_sum = !full ? SUM_W'(head_ff)
                     : (purge_sum >= DEPTH_S) ? purge_sum - DEPTH_S : purge_sum;
   assign head_p     = head_p_sum[PTR_W-1:0];
   assign cnt_p      = full ? count_ff - PURGE_C : count_ff;
   assign wr_sum     = SUM_W'(head_p) + SUM_W'(cnt_p);
   assign wr_addr    = (wr_sum >= DEPTH_S) ? PTR_W'(wr_sum - DEPTH_S) : PTR_W'(wr_sum);
   assign pop_sum    = SUM_W'(head_ff) + SUM_W'(1);

   // Watermark checks against the count plus the appended byte, before any purge
   assign count_plus = CMP_W'(count_ff) + CMP_W'(1);
   assign high_cmp   = CMP_W'(high_mark_ff);
   assign low_cmp    = CMP_W'(low_mark_ff);
   assign high_hit   = (high_mark_ff != '0) && (count_plus >= high_cmp) && !high_sent_ff;
   assign high_mid   = high_sent_ff || high_hit;
   assign low_hit    = (low_mark_ff != '0) && (count_plus <= low_cmp) && high_mid;

   assign wr_en = accept && !req_func && dec.keep;
   assign rd_en = accept && req_func && (count_ff != '0);

   // Next state and result fields
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      escape_in     = escape_ff;
      high_sent_in  = high_sent_ff;
      stored_in     = 1'b0;
      high_ev_in    = 1'b0;
      low_ev_in     = 1'b0;
      read_valid_in = 1'b0;
      if (rd_en) begin
         head_in       = (pop_sum >= DEPTH_S) ? PTR_W'(pop_sum - DEPTH_S) : PTR_W'(pop_sum);
         count_in      = count_ff - CNT_W'(1);
         read_valid_in = 1'b1;
      end else if (accept && !req_func) begin
         escape_in = dec.escape_next;
         if (dec.keep) begin
            head_in      = head_p;
            count_in     = cnt_p + CNT_W'(1);
            high_sent_in = high_mid && !low_hit;
            stored_in    = 1'b1;
            high_ev_in   = high_hit;
            low_ev_in    = low_hit;
         end
      end
   end

   // Store write and head read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fifo_mem[wr_addr] <= req_rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= fifo_mem[head_ff];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         escape_ff     <= 1'b0;
         high_sent_ff  <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         escape_ff     <= escape_in;
         high_sent_ff  <= high_sent_in;
         strobe_ff     <= accept;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_mark_ff <= '0;
         low_mark_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_HIGH_MARK: high_mark_ff <= csr_wdata;
            CSR_LOW_MARK:  low_mark_ff  <= csr_wdata;
         endcase
      end
   end

   // Hold result payload for the strobe cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         stored_ff     <= stored_in;
         high_ev_ff    <= high_ev_in;
         low_ev_ff     <= low_ev_in;
         read_valid_ff <= read_valid_in;
         fill_ff       <= count_in;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_stored     = stored_ff;
   assign rsp_high_event = high_ev_ff;
   assign rsp_low_event  = low_ev_ff;
   assign rsp_read_valid = read_valid_ff;
   assign rsp_read_byte  = read_valid_ff ? rd_data_ff : '0;
   assign rsp_fill_level = fill_ff;

endmodule

/* rtl/ebrf_unescape.sv */
// Unescape decoder: decides whether a link byte is kept and updates the escape flag.
module ebrf_unescape (
   input  logic [ebrf_pkg::BYTE_W-1:0] rx_byte,
   input  logic                        escape_pending,
   output ebrf_pkg::unesc_type         dec
);
   import ebrf_pkg::*;

   logic is_esc;
   logic is_idle;

   assign is_esc  = (rx_byte == ESC_BYTE);
   assign is_idle = (rx_byte == IDLE_LOW) || (rx_byte == IDLE_HIGH);

   // Keep any byte after an escape mark; otherwise drop marks and idle bytes
   always_comb begin
      if (escape_pending) begin
         dec.keep        = 1'b1;
         dec.escape_next = 1'b0;
      end else begin
         dec.keep        = !(is_esc || is_idle);
         dec.escape_next = is_esc;
      end
   end

endmodule

/* rtl/ebrf_checker.sv */
// Port-level checker of the escaped byte receive FIFO and its bind statement.
`include "escaped_byte_rx_fifo_unit_defines.svh"

module ebrf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic rsp_strobe,
   input logic rsp_stored,
   input logic rsp_high_event,
   input logic rsp_low_event,
   input logic rsp_read_valid
);

   // Every accepted request gives a result in the next cycle
   `EBRF_ASSERT_NEXT(a_result_follows, start && !busy, rsp_strobe, "missing result strobe")

   // A pop request never reports a stored byte
   `EBRF_ASSERT_NEXT(a_pop_not_stored, start && !busy && req_func, rsp_strobe && !rsp_stored, "pop reported as stored")

   // A stored byte never carries popped data
   `EBRF_ASSERT_NOW(a_store_no_read, rsp_strobe && rsp_stored, !rsp_read_valid, "stored result with read data")

   // Watermark events only come with a stored byte
   `EBRF_ASSERT_NOW(a_event_needs_store, rsp_strobe && !rsp_stored, !rsp_high_event && !rsp_low_event, "event without stored byte")

endmodule

bind escaped_byte_rx_fifo_unit ebrf_checker u_ebrf_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_func       (req_func),
   .rsp_strobe     (rsp_strobe),
   .rsp_stored     (rsp_stored),
   .rsp_high_event (rsp_high_event),
   .rsp_low_event  (rsp_low_event),
   .rsp_read_valid (rsp_read_valid)
);

/* test/testbench.sv */
// Self-checking testbench for the escaped byte receive FIFO with watermark events.
`timescale 1ns / 100ps

module testbench;
   import ebrf_pkg::*;

   localparam int FIFO_DEPTH    = 256;
   localparam int PURGE_BLOCK   = 8;
   localparam int LEVEL_W       = $clog2(FIFO_DEPTH + 1);
   localparam int MARK_MAX      = 256;
   localparam int MARK_ALL_ONES = 511;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_PCT      = 34;

   // Request function codes
   localparam logic FUNC_RECEIVE = 1'b0;
   localparam logic FUNC_POP     = 1'b1;

   typedef struct packed {
      logic               stored;
      logic               high_event;
      logic               low_event;
      logic               read_valid;
      logic [BYTE_W-1:0]  read_byte;
      logic [LEVEL_W-1:0] fill_level;
   } fifo_outcome_t;

   // Tracks unescape, watermark and ring state; holds the outcomes still due.
   class unescape_fifo_tracker;
      logic [BYTE_W-1:0] store [FIFO_DEPTH];
      int unsigned       head;
      int unsigned       level;
      bit                escape_armed;
      bit                high_sent;
      logic [MARK_W-1:0] high_mark;
      logic [MARK_W-1:0] low_mark;
      fifo_outcome_t     pending[$];
      int                errors;

      function new();
         head = 0;
         level = 0;
         escape_armed = 0;
         high_sent = 0;
         high_mark = '0;
         low_mark = '0;
         errors = 0;
      endfunction

      function void write_mark(csr_index_type idx, logic [MARK_W-1:0] value);
         case (idx)
            CSR_HIGH_MARK: high_mark = value;
            CSR_LOW_MARK:  low_mark = value;
            default: ;
         endcase
      endfunction

      // Advance the state by one accepted request and queue its outcome.
      function void note_request(logic func, logic [BYTE_W-1:0] rx_byte);
         fifo_outcome_t out;
         bit            keep;
         int unsigned   next_level;
         out = '0;
         if (func == FUNC_POP) begin
            if (level != 0) begin
               out.read_valid = 1'b1;
               out.read_byte = store[head];
               head = (head + 1) % FIFO_DEPTH;
               level--;
            end
         end else begin
            keep = 1'b1;
            if (escape_armed) begin
               escape_armed = 1'b0;
            end else if (rx_byte == ESC_BYTE) begin
               escape_armed = 1'b1;
               keep = 1'b0;
            end else if (rx_byte == IDLE_LOW || rx_byte == IDLE_HIGH) begin
               keep = 1'b0;
            end
            if (keep) begin
               next_level = level + 1;
               if (high_mark != 0 && next_level >= high_mark && !high_sent) begin
                  out.high_event = 1'b1;
                  high_sent = 1'b1;
               end
               if (low_mark != 0 && next_level <= low_mark && high_sent) begin
                  out.low_event = 1'b1;
                  high_sent = 1'b0;
               end
               // drop the oldest block when full
               if (level >= FIFO_DEPTH) begin
                  head = (head + PURGE_BLOCK) % FIFO_DEPTH;
                  level -= PURGE_BLOCK;
               end
               store[(head + level) % FIFO_DEPTH] = rx_byte;
               level++;
               out.stored = 1'b1;
            end
         end
         out.fill_level = level[LEVEL_W-1:0];
         pending.push_back(out);
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH %s", $time, msg);
         errors++;
      endtask

      task compare_field(string name, logic [LEVEL_W-1:0] got, logic [LEVEL_W-1:0] want);
         if (got !== want)
            report($sformatf("%s: got %0h expected %0h", name, got, want));
      endtask

      // Compare one strobed result against the oldest outcome due.
      task check_result(fifo_outcome_t got);
         fifo_outcome_t want;
         if (pending.size() == 0) begin
            report("result strobed with no request outstanding");
            return;
         end
         want = pending.pop_front();
         compare_field("stored", got.stored, want.stored);
         compare_field("high_event", got.high_event, want.high_event);
         compare_field("low_event", got.low_event, want.low_event);
         compare_field("read_valid", got.read_valid, want.read_valid);
         compare_field("read_byte", got.read_byte, want.read_byte);
         compare_field("fill_level", got.fill_level, want.fill_level);
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_func = FUNC_RECEIVE;
   logic [BYTE_W-1:0]   req_rx_byte = '0;
   logic                rsp_strobe;
   logic                rsp_stored;
   logic                rsp_high_event;
   logic                rsp_low_event;
   logic                rsp_read_valid;
   logic [BYTE_W-1:0]   rsp_read_byte;
   logic [LEVEL_W-1:0]  rsp_fill_level;
   logic                csr_write_en = 1'b0;
   csr_index_type       csr_index = CSR_HIGH_MARK;
   logic [MARK_W-1:0]   csr_wdata = '0;

   fifo_outcome_t        seen;
   unescape_fifo_tracker tracker = new();
   int                   quiet_cycles = 0;

   escaped_byte_rx_fifo_unit #(
      .DEPTH       (FIFO_DEPTH),
      .PURGE_BLOCK (PURGE_BLOCK)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_rx_byte    (req_rx_byte),
      .rsp_strobe     (rsp_strobe),
      .rsp_stored     (rsp_stored),
      .rsp_high_event (rsp_high_event),
      .rsp_low_event  (rsp_low_event),
      .rsp_read_valid (rsp_read_valid),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_fill_level (rsp_fill_level),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   assign seen = {rsp_stored, rsp_high_event, rsp_low_event, rsp_read_valid,
                  rsp_read_byte, rsp_fill_level};

   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   // Sample handshakes at the edge, update the tracker and run the watchdog.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (csr_write_en)
            tracker.write_mark(csr_index, csr_wdata);
         if (start && !busy)
            tracker.note_request(req_func, req_rx_byte);
         if (rsp_strobe)
            tracker.check_result(seen);
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles = 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // Hold one request until the block takes it.
   task automatic send(input logic func, input logic [BYTE_W-1:0] rx_byte);
      start <= 1'b1;
      req_func <= func;
      req_rx_byte <= rx_byte;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Idle each cycle with the given odds before the next request.
   task automatic idle_gap();
      while ($urandom_range(0, 99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [MARK_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_marks(input int high, input int low);
      write_csr(CSR_HIGH_MARK, high[MARK_W-1:0]);
      write_csr(CSR_LOW_MARK, low[MARK_W-1:0]);
      csr_write_en <= 1'b0;
   endtask

   // Stop sending and wait until every result is back.
   task automatic drain();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (tracker.pending.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Link byte mix: plenty of escapes and idle bytes, the rest uniform.
   function automatic logic [BYTE_W-1:0] link_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         return ESC_BYTE;
      else if (pick < 17)
         return IDLE_LOW;
      else if (pick < 22)
         return IDLE_HIGH;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic run_phase(input int items, input int pop_pct, input bit allow_idle);
      logic func;
      for (int i = 0; i < items; i++) begin
         if (allow_idle)
            idle_gap();
         func = ($urandom_range(0, 99) < pop_pct) ? FUNC_POP : FUNC_RECEIVE;
         send(func, link_byte());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle drops, escapes, pops on empty, both watermark events
      set_marks(3, 1);
      send(FUNC_POP, 8'h00);
      send(FUNC_RECEIVE, IDLE_LOW);
      send(FUNC_RECEIVE, IDLE_HIGH);
      send(FUNC_RECEIVE, ESC_BYTE);
      send(FUNC_RECEIVE, IDLE_HIGH);
      send(FUNC_RECEIVE, ESC_BYTE);
      send(FUNC_RECEIVE, ESC_BYTE);
      send(FUNC_RECEIVE, 8'h01);
      send(FUNC_RECEIVE, 8'h80);
      send(FUNC_RECEIVE, 8'h7F);
      send(FUNC_RECEIVE, 8'hFE);
      // a pop between escape and its byte leaves the escape armed
      send(FUNC_RECEIVE, ESC_BYTE);
      send(FUNC_POP, 8'hFF);
      send(FUNC_RECEIVE, IDLE_LOW);
      repeat (6) send(FUNC_POP, 8'h00);
      send(FUNC_RECEIVE, 8'h41);
      send(FUNC_POP, 8'h00);
      send(FUNC_POP, 8'h00);
      send(FUNC_RECEIVE, ESC_BYTE);
      send(FUNC_POP, 8'hA5);
      send(FUNC_RECEIVE, IDLE_LOW);
      drain();

      // Fill past full so the oldest block gets purged
      set_marks(200, 40);
      run_phase(450, 5, 1'b1);
      drain();

      // Drain hard with top-of-range marks; many pops on empty
      set_marks(MARK_MAX, MARK_MAX);
      run_phase(300, 70, 1'b1);
      drain();

      // Low mark above high mark: both events on one byte
      set_marks(16, 64);
      run_phase(300, 45, 1'b1);
      drain();

      set_marks(0, MARK_ALL_ONES);
      run_phase(200, 35, 1'b1);
      drain();

      // Back-to-back requests with random marks
      set_marks($urandom_range(0, MARK_MAX), $urandom_range(0, MARK_MAX));
      run_phase(300, 40, 1'b0);
      drain();

      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* escaped_byte_rx_fifo_unit.f */
+incdir+rtl
rtl/ebrf_pkg.sv
rtl/ebrf_unescape.sv
rtl/escaped_byte_rx_fifo_unit.sv
rtl/ebrf_checker.sv
test/testbench.sv
